// File: rtl/core/brsb_pkg.sv
// Shared types, opcodes and stub word encoding for the branch relocating stub builder.
// No dependencies.
`default_nettype none

package brsb_pkg;

    localparam logic [31:0] OP_MASK    = 32'hFC00_0000;
    localparam logic [31:0] OP_B       = 32'h4800_0000;
    localparam logic [31:0] OP_BC      = 32'h4000_0000;
    localparam logic [31:0] W_LIS_R0   = 32'h3C00_0000;
    localparam logic [31:0] W_ORI_R0   = 32'h6000_0000;
    localparam logic [31:0] W_MTCTR_R0 = 32'h7C09_03A6;
    localparam logic [31:0] W_BCCTR    = 32'h4C00_0420;
    localparam logic [31:0] W_STD_R0   = 32'hF800_0000;
    localparam logic [31:0] W_LD_R0    = 32'hE800_0000;
    localparam logic [31:0] R1_FIELD   = 32'h0001_0000;
    localparam logic [31:0] SAVE_DISP  = 32'h0000_FFD0;
    localparam logic [4:0]  BO_ALWAYS  = 5'd20;
    localparam logic [4:0]  BI_NONE    = 5'd0;

    localparam int unsigned JUMP_LEN = 6;
    localparam int unsigned STEP_W   = $clog2(JUMP_LEN);
    localparam logic [STEP_W-1:0] STEP_STD   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_LIS   = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_ORI   = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_MTCTR = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_LD    = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_BCCTR = STEP_W'(5);

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic        is_jump;
        logic [31:0] word;
        logic [4:0]  bo;
        logic [4:0]  bi;
        logic        lk;
        logic        fin;
        logic [31:0] ret_target;
    } job_t;

    function automatic logic [31:0] jump_word(input step_t step, input logic [31:0] target,
                                              input logic [4:0] bo, input logic [4:0] bi,
                                              input logic lk);
        logic [31:0] w;
        w = W_MTCTR_R0;
        unique case (step)
            STEP_STD:   w = W_STD_R0 | R1_FIELD | SAVE_DISP;
            STEP_LIS:   w = W_LIS_R0 | {16'h0000, target[31:16]};
            STEP_ORI:   w = W_ORI_R0 | {16'h0000, target[15:0]};
            STEP_MTCTR: w = W_MTCTR_R0;
            STEP_LD:    w = W_LD_R0 | R1_FIELD | SAVE_DISP;
            STEP_BCCTR: w = W_BCCTR | {6'd0, bo, bi, 15'd0, lk};
            default:    w = W_MTCTR_R0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/brsb_front.sv
// Front end: takes one instruction beat, decodes relative branches, computes targets.
// Depends on brsb_pkg.
`default_nettype none

module brsb_front
    import brsb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] in_word,
    input  wire logic [31:0] in_addr,
    input  wire logic        in_fin,
    output logic             job_valid,
    input  wire logic        job_ready,
    output job_t             job
);

    logic        valid_reg, valid_next;
    job_t        job_reg, job_next;
    logic [31:0] op;
    logic        is_b, is_bc;
    logic [31:0] off;

    always_comb begin
        op    = in_word & OP_MASK;
        is_b  = (op == OP_B) && !in_word[1];
        is_bc = (op == OP_BC) && !in_word[1];
        if (is_b) begin
            off = {{6{in_word[25]}}, in_word[25:2], 2'b00};
        end else begin
            off = {{16{in_word[15]}}, in_word[15:2], 2'b00};
        end
        job_next.is_jump    = is_b || is_bc;
        job_next.word       = (is_b || is_bc) ? in_addr + off : in_word;
        job_next.bo         = is_b ? BO_ALWAYS : in_word[25:21];
        job_next.bi         = is_b ? BI_NONE : in_word[20:16];
        job_next.lk         = in_word[0];
        job_next.fin        = in_fin;
        job_next.ret_target = in_addr + 32'd4;
    end

    assign in_ready  = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (job_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            job_reg <= job_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/brsb_queue.sv
// Short job queue between front and back ends.
// Depends on brsb_pkg.
`default_nettype none

module brsb_queue
    import brsb_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire job_t push_job,
    output logic      head_valid,
    input  wire logic pop,
    output job_t      head_job
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/brsb_back.sv
// Back end: walks the head job word by word into a registered output beat.
// Depends on brsb_pkg.
`default_nettype none

module brsb_back
    import brsb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        head_valid,
    input  wire job_t        head_job,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_word,
    output logic             out_last
);

    step_t       step_reg, step_next;
    logic        ret_reg, ret_next;
    logic        valid_reg, valid_next;
    logic [31:0] word_reg, word_next;
    logic        last_reg, last_next;
    logic        load, fire, seg_end, item_end;
    logic [31:0] target;
    logic [4:0]  bo, bi;
    logic        lk;

    assign load = !valid_reg || out_ready;
    assign fire = head_valid && load;

    always_comb begin
        target    = ret_reg ? head_job.ret_target : head_job.word;
        bo        = ret_reg ? BO_ALWAYS : head_job.bo;
        bi        = ret_reg ? BI_NONE : head_job.bi;
        lk        = ret_reg ? 1'b0 : head_job.lk;
        word_next = (!ret_reg && !head_job.is_jump) ? head_job.word
                                                    : jump_word(step_reg, target, bo, bi, lk);
        seg_end   = (step_reg == STEP_BCCTR) || (!ret_reg && !head_job.is_jump);
        item_end  = seg_end && (ret_reg || !head_job.fin);
        last_next = item_end;
    end

    assign pop = fire && item_end;

    always_comb begin
        step_next  = step_reg;
        ret_next   = ret_reg;
        valid_next = valid_reg;
        if (fire) begin
            valid_next = 1'b1;
            if (seg_end) begin
                step_next = STEP_STD;
                ret_next  = !item_end;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_STD;
            ret_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            ret_reg   <= ret_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            word_reg <= word_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/branch_relocating_stub_builder_top.sv
// Branch relocating stub builder, top level: front decode, job queue, back sequencer.
// Path: an accepted input beat passes the front register, the queue and the output register.
// Throughput: one output beat per cycle while m_tready allows, set by the back sequencer;
// an input yields one word (copied word) or six (relocated branch), plus six more when final.
// Reset: synchronous active-low aresetn empties the front register, queue and output.
// Depends on brsb_pkg, brsb_front, brsb_queue, brsb_back.
`default_nettype none

module branch_relocating_stub_builder_top
    import brsb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // instr_word[31:0], instr_addr[63:32]
    input  wire logic        s_tlast,   // final_source
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // stub_word[31:0]
    output logic             m_tlast    // last_of_run
);

    logic job_valid, job_ready;
    job_t job;
    logic head_valid, pop;
    job_t head_job;

    brsb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_tdata[31:0]),
        .in_addr   (s_tdata[63:32]),
        .in_fin    (s_tlast),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    brsb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (job_valid),
        .push_ready (job_ready),
        .push_job   (job),
        .head_valid (head_valid),
        .pop        (pop),
        .head_job   (head_job)
    );

    brsb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_word   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

`default_nettype wire

// File: test/branch_relocating_stub_builder_top_tb.sv
// Self-checking testbench for branch_relocating_stub_builder_top: a directed table, then
// random instruction words over valid/ready streams, checked against a local stub predictor.
// Depends on brsb_pkg and the RTL under rtl/core.
module branch_relocating_stub_builder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brsb_pkg::*;

    localparam logic [31:0] AA_MASK      = 32'h0000_0002;
    localparam int unsigned RANDOM_ITEMS = 150;
    localparam int unsigned WATCHDOG_MAX = 2000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned DIR_ROWS     = 20;

    typedef struct packed {
        logic [31:0] word;
        logic        tail;
    } stub_beat_t;

    typedef struct packed {
        logic [31:0] word;
        logic [31:0] addr;
        logic        fin;
        logic        typed;     // expected: copy_exp as the only beat
        logic [31:0] copy_exp;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;    // instr_word[31:0], instr_addr[63:32]
    logic        s_tlast  = 1'b0;  // final_source
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // stub_word[31:0]
    logic        m_tlast;          // last_of_run

    stub_beat_t  stub_q[$];
    stub_beat_t  head_beat;
    int          src_gap_pct  = 0;
    int          sink_gap_pct = 0;
    int          errors       = 0;
    int          items_sent   = 0;
    int          words_seen   = 0;
    int          n_reloc      = 0;
    int          n_return     = 0;
    int          idle_cycles  = 0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
        '{32'h4800_0000, 32'h0000_1000, 1'b0, 1'b0, 32'h0},
        '{32'h49FF_FFFC, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h4A00_0000, 32'h0000_0010, 1'b0, 1'b0, 32'h0},
        '{32'h4800_0101, 32'hFFFF_FF00, 1'b0, 1'b0, 32'h0},
        '{32'h4800_0002, 32'h0000_2000, 1'b0, 1'b1, 32'h4800_0002},
        '{32'h4BFF_FFFF, 32'h0000_2004, 1'b0, 1'b1, 32'h4BFF_FFFF},
        '{32'h4000_FFFC, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h43FF_7FFD, 32'hFFFF_FFF0, 1'b0, 1'b0, 32'h0},
        '{32'h4000_8000, 32'h0000_4000, 1'b0, 1'b0, 32'h0},
        '{32'h4282_0012, 32'h0000_4004, 1'b0, 1'b1, 32'h4282_0012},
        '{32'h4C00_0020, 32'h0000_4008, 1'b0, 1'b1, 32'h4C00_0020},
        '{32'h4400_0002, 32'h0000_400C, 1'b0, 1'b1, 32'h4400_0002},
        '{32'h7C08_03A6, 32'hDEAD_BEEC, 1'b0, 1'b1, 32'h7C08_03A6},
        '{32'h6000_0000, 32'hFFFF_FFFC, 1'b1, 1'b0, 32'h0},
        '{32'h4BFF_FFFD, 32'h1234_5678, 1'b1, 1'b0, 32'h0},
        '{32'h4182_0010, 32'h0000_0100, 1'b1, 1'b0, 32'h0},
        '{32'h4800_0002, 32'h5555_5554, 1'b1, 1'b0, 32'h0},
        '{32'hAAAA_AAAA, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0}
    };

    branch_relocating_stub_builder_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    function automatic void add_jump(input logic [31:0] target, input logic [4:0] bo,
                                     input logic [4:0] bi, input logic lk, input logic tail);
        stub_q.push_back('{W_STD_R0 | R1_FIELD | SAVE_DISP, 1'b0});
        stub_q.push_back('{W_LIS_R0 | {16'h0000, target[31:16]}, 1'b0});
        stub_q.push_back('{W_ORI_R0 | {16'h0000, target[15:0]}, 1'b0});
        stub_q.push_back('{W_MTCTR_R0, 1'b0});
        stub_q.push_back('{W_LD_R0 | R1_FIELD | SAVE_DISP, 1'b0});
        stub_q.push_back('{W_BCCTR | {6'd0, bo, bi, 15'd0, lk}, tail});
    endfunction

    function automatic void predict_stub(input logic [31:0] w, input logic [31:0] a,
                                         input logic fin);
        logic [31:0] op;
        op = w & OP_MASK;
        if ((op == OP_B || op == OP_BC) && (w & AA_MASK) == 32'h0) begin
            n_reloc++;
            if (op == OP_B)
                add_jump(a + {{6{w[25]}}, w[25:2], 2'b00}, BO_ALWAYS, BI_NONE, w[0], !fin);
            else
                add_jump(a + {{16{w[15]}}, w[15:2], 2'b00}, w[25:21], w[20:16], w[0], !fin);
        end else begin
            stub_q.push_back('{w, !fin});
        end
        if (fin) begin
            n_return++;
            add_jump(a + 32'd4, BO_ALWAYS, BI_NONE, 1'b0, 1'b1);
        end
    endfunction

    task automatic push_instr(input logic [31:0] w, input logic [31:0] a, input logic fin,
                              input logic typed, input logic [31:0] copy_exp);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {a, w};
        s_tlast  <= fin;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (typed)
            stub_q.push_back('{copy_exp, 1'b1});
        else
            predict_stub(w, a, fin);
    endtask

    task automatic push_random();
        logic [31:0] w;
        logic [31:0] a;
        int          kind;
        kind = $urandom_range(99);
        w = $urandom;
        if (kind < 35)
            w = OP_B | (w & ~OP_MASK);
        else if (kind < 65)
            w = OP_BC | (w & ~OP_MASK);
        if (kind < 65 && $urandom_range(99) < 80)
            w = w & ~AA_MASK;
        a = $urandom;
        if ($urandom_range(99) < 85)
            a[1:0] = 2'b00;
        push_instr(w, a, $urandom_range(99) < 20, 1'b0, 32'h0);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_gap_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                words_seen++;
                if (stub_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected stub beat: expected none, got word %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    head_beat = stub_q.pop_front();
                    if (m_tdata !== head_beat.word) begin
                        errors++;
                        $display("%0t: stub_word mismatch: expected %h, got %h",
                                 $time, head_beat.word, m_tdata);
                    end
                    if (m_tlast !== head_beat.tail) begin
                        errors++;
                        $display("%0t: last_of_run mismatch: expected %b, got %b",
                                 $time, head_beat.tail, m_tlast);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("%0t: no beat moved for %0d cycles, %0d stub words outstanding",
                         $time, idle_cycles, stub_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        src_gap_pct  = 32;
        sink_gap_pct = 73;
        foreach (dir_tab[i])
            push_instr(dir_tab[i].word, dir_tab[i].addr, dir_tab[i].fin, dir_tab[i].typed,
                       dir_tab[i].copy_exp);
        repeat (55) push_random();

        src_gap_pct  = 73;
        sink_gap_pct = 32;
        repeat (55) push_random();

        src_gap_pct  = 0;
        sink_gap_pct = 0;
        repeat (RANDOM_ITEMS - 110) push_random();

        s_tvalid <= 1'b0;
        while (stub_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d instruction words (%0d directed), checked %0d stub words.",
                 items_sent, DIR_ROWS, words_seen);
        $display("Relocated %0d relative branches and appended %0d return jumps.",
                 n_reloc, n_return);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
